@@ src/cpit_pkg.sv @@
// ----------------------------------------------------------------------------
// cpit_pkg
// Shared codes, widths and helpers for the constant pool interning table.
// ----------------------------------------------------------------------------
package cpit_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ENTRY_W = VALUE_W + KIND_W;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [VALUE_W-1:0] value_t;

	localparam kind_t OP_INT  = 2'd0;
	localparam kind_t OP_DBL  = 2'd1;
	localparam kind_t OP_RAW  = 2'd2;
	localparam kind_t OP_NONE = 2'd3;

	localparam value_t EXP_MASK  = 64'h7FF0_0000_0000_0000;
	localparam value_t FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;
	localparam value_t MAG_MASK  = 64'h7FFF_FFFF_FFFF_FFFF;

	function automatic logic dbl_is_nan(input value_t b);
		return ((b & EXP_MASK) == EXP_MASK) && ((b & FRAC_MASK) != '0);
	endfunction

	// IEEE equality on bit patterns: both zeros match, NaN matches nothing.
	function automatic logic dbl_equal(input value_t a, input value_t b);
		logic res;
		if (dbl_is_nan(a) || dbl_is_nan(b)) begin
			res = 1'b0;
		end else if (((a & MAG_MASK) == '0) && ((b & MAG_MASK) == '0)) begin
			res = 1'b1;
		end else begin
			res = (a == b);
		end
		return res;
	endfunction

endpackage

@@ src/cpit_ram.sv @@
// ----------------------------------------------------------------------------
// cpit_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module cpit_ram #(
	parameter int unsigned WIDTH = 66,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ src/constant_pool_interning_table.sv @@
// ----------------------------------------------------------------------------
// constant_pool_interning_table
// Interns typed 64-bit constants: integer and double requests search earlier
// entries of the same kind and append on a miss, raw requests append unsearched.
// ----------------------------------------------------------------------------
// Sequence: an intern request that misses scans every entry, then appends (or
// flags full_res if the pool is full); a hit ends the scan at the match; a raw
// request or an intern into an empty pool goes straight to the append, an
// unused op code straight to the result. One request at a time; the linear
// scan reads one RAM entry per cycle through the single read port.
// Reset: arst_n clears the entry count, the state and the output valid; RAM
// contents are not cleared, entries above the count are never read.
// ----------------------------------------------------------------------------
module constant_pool_interning_table #(
	parameter int unsigned POOL_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Request channel
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [1:0] op, [65:2] value, [71:66] zero
	input  logic [cpit_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// Result channel
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [5:0] index, [6] found, [7] full_res
	output logic [cpit_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	localparam int unsigned AW = $clog2(POOL_DEPTH);
	localparam int unsigned CW = $clog2(POOL_DEPTH + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SEARCH = 2'd1;
	localparam logic [1:0] ST_APPEND = 2'd2;
	localparam logic [1:0] ST_RESULT = 2'd3;

	logic [1:0]              state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           issue_q;
	cpit_pkg::kind_t         op_q;
	cpit_pkg::value_t        value_q;

	// Compare stage follows the RAM read in the next cycle
	logic                    cmp_v_s1;
	logic [AW-1:0]           cmp_addr_s1;

	// Pending result, held until the output register is free
	logic [CW-1:0]           res_idx_q;
	logic                    res_found_q;
	logic                    res_full_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_raddr;
	logic [cpit_pkg::ENTRY_W-1:0] ram_rdata;
	cpit_pkg::kind_t         rd_kind;
	cpit_pkg::value_t        rd_value;
	logic                    rd_match;
	logic                    rd_last;
	logic                    issue_more;
	logic                    in_xfer;
	logic                    out_free;
	logic [CW+cpit_pkg::INDEX_W-1:0] idx_wide;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	assign issue_more = (issue_q < count_q);
	assign ram_raddr  = issue_q[AW-1:0];
	assign ram_we     = (state_q == ST_APPEND) && (count_q < CW'(POOL_DEPTH));

	assign rd_kind  = ram_rdata[cpit_pkg::ENTRY_W-1:cpit_pkg::VALUE_W];
	assign rd_value = ram_rdata[cpit_pkg::VALUE_W-1:0];

	// Match only within the same kind; doubles use IEEE equality
	always_comb begin
		rd_match = 1'b0;
		if (rd_kind == op_q) begin
			case (op_q)
				cpit_pkg::OP_INT: rd_match = (rd_value == value_q);
				cpit_pkg::OP_DBL: rd_match = cpit_pkg::dbl_equal(rd_value, value_q);
				default:          rd_match = 1'b0;
			endcase
		end
	end

	assign rd_last = ((CW'(cmp_addr_s1) + CW'(1)) == count_q);

	cpit_ram #(
		.WIDTH(cpit_pkg::ENTRY_W),
		.DEPTH(POOL_DEPTH)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata({op_q, value_q}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Control: accept, scan, append on a miss or raw request, then hand off the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cmp_v_s1 <= 1'b0;
					if (in_xfer) begin
						if (s_axis_tdata[1:0] == cpit_pkg::OP_NONE) begin
							state_q <= ST_RESULT;
						end else if (s_axis_tdata[1:0] == cpit_pkg::OP_RAW ||
						             count_q == '0) begin
							state_q <= ST_APPEND;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					cmp_v_s1 <= issue_more;
					if (cmp_v_s1 && rd_match) begin
						state_q  <= ST_RESULT;
						cmp_v_s1 <= 1'b0;
					end else if (cmp_v_s1 && rd_last) begin
						state_q  <= ST_APPEND;
						cmp_v_s1 <= 1'b0;
					end
				end
				ST_APPEND: begin
					if (ram_we) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: request, scan pointer, pending result
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				issue_q     <= '0;
				res_idx_q   <= '0;
				res_found_q <= 1'b0;
				res_full_q  <= 1'b0;
				if (in_xfer) begin
					op_q    <= s_axis_tdata[1:0];
					value_q <= s_axis_tdata[cpit_pkg::ENTRY_W-1:cpit_pkg::KIND_W];
				end
			end
			ST_SEARCH: begin
				if (issue_more) begin
					issue_q <= issue_q + CW'(1);
				end
				cmp_addr_s1 <= ram_raddr;
				if (cmp_v_s1 && rd_match) begin
					res_idx_q   <= CW'(cmp_addr_s1);
					res_found_q <= 1'b1;
				end
			end
			ST_APPEND: begin
				if (ram_we) begin
					res_idx_q <= count_q;
				end else begin
					res_full_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign idx_wide = {{cpit_pkg::INDEX_W{1'b0}}, res_idx_q};

	// Output register: load the result when the previous transfer is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (state_q == ST_RESULT && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESULT && out_free) begin
			m_axis_tdata <= {res_full_q, res_found_q, idx_wide[cpit_pkg::INDEX_W-1:0]};
		end
	end

endmodule
